@@ rtl/llf_pkg.sv @@
// Shared types and constants for the ladder lowpass filter.
package llf_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 18;
  localparam int ST_W      = 24;
  localparam int CFG_IDX_W = 2;
  localparam int FRAC_W    = 17;
  localparam int TBL_W     = 16;

  localparam int MUL_A_W = COEF_W + 1;
  localparam int MUL_B_W = ST_W + 3;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam int X_W     = 31;

  localparam logic [CFG_IDX_W-1:0] REG_COEF_B0  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B1  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A1  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RES_GAIN = 2'd3;

  localparam logic [TBL_W-1:0] TANH_ONE = 16'd16384;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_FB_MUL,
    OP_FB_SUM,
    OP_TPOS,
    OP_ROM,
    OP_TMUL,
    OP_TFIN,
    OP_MUL_B0,
    OP_MUL_B1,
    OP_MUL_A1,
    OP_STAGE_END,
    OP_LOAD_OUT
  } dp_op_t;

  typedef struct packed {
    logic   load_in;
    dp_op_t op;
  } dp_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FB_MUL,
    ST_FB_SUM,
    ST_TPOS,
    ST_ROM,
    ST_TMUL,
    ST_TFIN,
    ST_MUL_B0,
    ST_MUL_B1,
    ST_MUL_A1,
    ST_STAGE_END,
    ST_OUT
  } ctrl_state_t;

endpackage

@@ rtl/llf_datapath.sv @@
// Datapath: config registers, shared multiplier, tanh ROM and stage history.
module llf_datapath #(
  parameter int STAGES           = 4,
  parameter int TANH_TABLE_DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [llf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [llf_pkg::COEF_W-1:0]          cfg_wdata,
  input  logic signed [llf_pkg::SAMPLE_W-1:0] sample_in,
  input  llf_pkg::dp_cmd_t                    cmd,
  output logic [llf_pkg::SAMPLE_W-1:0]        sample_out
);

  localparam int IW     = $clog2(TANH_TABLE_DEPTH);
  localparam int DW     = $clog2(TANH_TABLE_DEPTH + 1);
  localparam int POS_W  = llf_pkg::X_W + DW;
  localparam int PIDX_W = POS_W - llf_pkg::FRAC_W;
  localparam int RND_W  = llf_pkg::PROD_W + 1;
  localparam int TV_W   = llf_pkg::TBL_W + 2;

  localparam logic [63:0] Q30    = 64'd1 << 30;
  localparam logic [63:0] STEP_A = (64'd16 << 30) / TANH_TABLE_DEPTH;

  typedef logic [llf_pkg::TBL_W-1:0] rom_t [TANH_TABLE_DEPTH];

  // shift-subtract quotient for table construction; quotient must fit in qbits
  function automatic logic [63:0] const_udiv(input logic [63:0] n, input logic [63:0] d,
                                             input int qbits);
    logic [63:0] rem;
    logic [63:0] q;
    rem = n;
    q   = '0;
    for (int b = qbits - 1; b >= 0; b--) begin
      if ((d << b) <= rem) begin
        rem  = rem - (d << b);
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic rom_t build_table(input logic [63:0] a);
    logic [63:0] term;
    logic [63:0] r;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] num;
    rom_t        tb;
    term = Q30;
    r    = Q30;
    e    = Q30;
    for (int i = 1; i <= 20; i++) begin
      term = const_udiv((term * a) >> 30, 64'(i), 32);
      if (i[0]) begin
        r = r - term;
      end else begin
        r = r + term;
      end
    end
    for (int k = 0; k < TANH_TABLE_DEPTH; k++) begin
      den   = Q30 + e;
      num   = (Q30 - e) * 64'd16384 + (den >> 1);
      tb[k] = llf_pkg::TBL_W'(const_udiv(num, den, 16));
      e     = (e * r + (Q30 >> 1)) >> 30;
    end
    return tb;
  endfunction

  localparam rom_t TANH_ROM = build_table(STEP_A);

  logic signed [llf_pkg::COEF_W-1:0]   coef_b0;
  logic signed [llf_pkg::COEF_W-1:0]   coef_b1;
  logic signed [llf_pkg::COEF_W-1:0]   coef_a1;
  logic        [llf_pkg::COEF_W-1:0]   res_gain;

  logic signed [llf_pkg::SAMPLE_W-1:0] smp;
  logic signed [llf_pkg::PROD_W-1:0]   prod;
  logic signed [llf_pkg::ACC_W-1:0]    acc;
  logic signed [llf_pkg::X_W-1:0]      x;
  logic        [IW-1:0]                idx;
  logic        [llf_pkg::FRAC_W-1:0]   frac;
  logic                                neg;
  logic                                sat;
  logic        [llf_pkg::TBL_W-1:0]    rom_lo;
  logic        [llf_pkg::TBL_W-1:0]    rom_hi;
  logic signed [llf_pkg::ST_W-1:0]     xs;
  logic signed [llf_pkg::ST_W-1:0]     pin  [STAGES];
  logic signed [llf_pkg::ST_W-1:0]     pout [STAGES];

  logic signed [llf_pkg::MUL_A_W-1:0]  mul_a;
  logic signed [llf_pkg::MUL_B_W-1:0]  mul_b;
  logic signed [llf_pkg::MUL_B_W-1:0]  fb_op;
  logic signed [RND_W-1:0]             fb_rnd;
  logic        [llf_pkg::X_W-1:0]      mag;
  logic        [POS_W-1:0]             pos;
  logic                                sat_c;
  logic                                last_ent;
  logic        [IW-1:0]                rd_lo;
  logic        [IW-1:0]                rd_hi;
  logic        [llf_pkg::TBL_W-1:0]    hi_val;
  logic signed [llf_pkg::FRAC_W-1:0]   diff;
  logic signed [llf_pkg::PROD_W-1:0]   t_rnd;
  logic signed [TV_W-1:0]              t_val;
  logic signed [llf_pkg::ACC_W-1:0]    st_sum;
  logic signed [llf_pkg::ACC_W-1:0]    st_rnd;
  logic signed [llf_pkg::ST_W-1:0]     st_y;

  always_comb begin
    fb_op  = (llf_pkg::MUL_B_W'(smp) <<< 1) - (llf_pkg::MUL_B_W'(pout[STAGES-1]) <<< 2);
    fb_rnd = (RND_W'(prod) + RND_W'(32'sd32768)) >>> 16;

    mag   = x[llf_pkg::X_W-1] ? llf_pkg::X_W'(-x) : llf_pkg::X_W'(x);
    pos   = POS_W'(mag) * POS_W'(TANH_TABLE_DEPTH);
    sat_c = pos[POS_W-1:llf_pkg::FRAC_W] >= PIDX_W'(TANH_TABLE_DEPTH);

    last_ent = idx == IW'(TANH_TABLE_DEPTH - 1);
    rd_lo    = sat ? '0 : idx;
    rd_hi    = (sat || last_ent) ? rd_lo : idx + IW'(1);
    hi_val   = last_ent ? llf_pkg::TANH_ONE : rom_hi;
    diff     = $signed({1'b0, hi_val}) - $signed({1'b0, rom_lo});

    t_rnd = (prod + llf_pkg::PROD_W'(32'sd65536)) >>> 17;
    t_val = sat ? $signed(TV_W'(llf_pkg::TANH_ONE))
                : $signed({2'b00, rom_lo}) + TV_W'(t_rnd);

    st_sum = acc + llf_pkg::ACC_W'(prod);
    st_rnd = (st_sum + llf_pkg::ACC_W'(32'sd32768)) >>> 16;
    if (st_rnd > llf_pkg::ACC_W'(32'sd8388607)) begin
      st_y = 24'sd8388607;
    end else if (st_rnd < llf_pkg::ACC_W'(-32'sd8388608)) begin
      st_y = -24'sd8388608;
    end else begin
      st_y = llf_pkg::ST_W'(st_rnd);
    end

    case (cmd.op)
      llf_pkg::OP_FB_MUL: begin
        mul_a = $signed({1'b0, res_gain});
        mul_b = fb_op;
      end
      llf_pkg::OP_TMUL: begin
        mul_a = llf_pkg::MUL_A_W'(diff);
        mul_b = $signed(llf_pkg::MUL_B_W'(frac));
      end
      llf_pkg::OP_MUL_B0: begin
        mul_a = llf_pkg::MUL_A_W'(coef_b0);
        mul_b = llf_pkg::MUL_B_W'(xs);
      end
      llf_pkg::OP_MUL_B1: begin
        mul_a = llf_pkg::MUL_A_W'(coef_b1);
        mul_b = llf_pkg::MUL_B_W'(pin[0]);
      end
      llf_pkg::OP_MUL_A1: begin
        mul_a = llf_pkg::MUL_A_W'(coef_a1);
        mul_b = llf_pkg::MUL_B_W'(pout[0]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0  <= '0;
      coef_b1  <= '0;
      coef_a1  <= 18'sd65536;
      res_gain <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        llf_pkg::REG_COEF_B0:  coef_b0  <= $signed(cfg_wdata);
        llf_pkg::REG_COEF_B1:  coef_b1  <= $signed(cfg_wdata);
        llf_pkg::REG_COEF_A1:  coef_a1  <= $signed(cfg_wdata);
        llf_pkg::REG_RES_GAIN: res_gain <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STAGES; i++) begin
        pin[i]  <= '0;
        pout[i] <= '0;
      end
    end else if (cmd.op == llf_pkg::OP_STAGE_END) begin
      // rotate so the next stage's history sits at slot 0
      for (int i = 0; i < STAGES - 1; i++) begin
        pin[i]  <= pin[i+1];
        pout[i] <= pout[i+1];
      end
      pin[STAGES-1]  <= xs;
      pout[STAGES-1] <= st_y;
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (cmd.load_in) begin
      smp <= sample_in;
    end
    case (cmd.op)
      llf_pkg::OP_FB_SUM: begin
        x <= llf_pkg::X_W'(smp) + llf_pkg::X_W'(fb_rnd);
      end
      llf_pkg::OP_TPOS: begin
        idx  <= pos[llf_pkg::FRAC_W+IW-1:llf_pkg::FRAC_W];
        frac <= pos[llf_pkg::FRAC_W-1:0];
        neg  <= x[llf_pkg::X_W-1];
        sat  <= sat_c;
      end
      llf_pkg::OP_ROM: begin
        rom_lo <= TANH_ROM[rd_lo];
        rom_hi <= TANH_ROM[rd_hi];
      end
      llf_pkg::OP_TFIN: begin
        xs <= neg ? -llf_pkg::ST_W'(t_val) : llf_pkg::ST_W'(t_val);
      end
      llf_pkg::OP_MUL_B1: begin
        acc <= llf_pkg::ACC_W'(prod);
      end
      llf_pkg::OP_MUL_A1: begin
        acc <= st_sum;
      end
      llf_pkg::OP_STAGE_END: begin
        xs <= st_y;
      end
      llf_pkg::OP_LOAD_OUT: begin
        if (xs > 24'sd32767) begin
          sample_out <= 16'h7fff;
        end else if (xs < -24'sd32768) begin
          sample_out <= 16'h8000;
        end else begin
          sample_out <= xs[llf_pkg::SAMPLE_W-1:0];
        end
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/llf_ctrl.sv @@
// Controller: sequences feedback, tanh lookup and the stages; owns handshakes.
module llf_ctrl #(
  parameter int STAGES = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  output logic             m_tvalid,
  input  logic             m_tready,
  output llf_pkg::dp_cmd_t cmd
);

  localparam int SW = (STAGES > 1) ? $clog2(STAGES) : 1;

  llf_pkg::ctrl_state_t state;
  llf_pkg::ctrl_state_t state_next;
  logic [SW-1:0]        stage;
  logic [SW-1:0]        stage_next;
  logic                 m_tvalid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= llf_pkg::ST_IDLE;
      stage    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      stage    <= stage_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_comb begin
    state_next    = state;
    stage_next    = stage;
    m_tvalid_next = m_tvalid && !m_tready;
    s_tready      = 1'b0;
    cmd.load_in   = 1'b0;
    cmd.op        = llf_pkg::OP_NONE;
    case (state)
      llf_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = llf_pkg::ST_FB_MUL;
        end
      end
      llf_pkg::ST_FB_MUL: begin
        cmd.op     = llf_pkg::OP_FB_MUL;
        state_next = llf_pkg::ST_FB_SUM;
      end
      llf_pkg::ST_FB_SUM: begin
        cmd.op     = llf_pkg::OP_FB_SUM;
        state_next = llf_pkg::ST_TPOS;
      end
      llf_pkg::ST_TPOS: begin
        cmd.op     = llf_pkg::OP_TPOS;
        state_next = llf_pkg::ST_ROM;
      end
      llf_pkg::ST_ROM: begin
        cmd.op     = llf_pkg::OP_ROM;
        state_next = llf_pkg::ST_TMUL;
      end
      llf_pkg::ST_TMUL: begin
        cmd.op     = llf_pkg::OP_TMUL;
        state_next = llf_pkg::ST_TFIN;
      end
      llf_pkg::ST_TFIN: begin
        cmd.op     = llf_pkg::OP_TFIN;
        stage_next = '0;
        state_next = llf_pkg::ST_MUL_B0;
      end
      llf_pkg::ST_MUL_B0: begin
        cmd.op     = llf_pkg::OP_MUL_B0;
        state_next = llf_pkg::ST_MUL_B1;
      end
      llf_pkg::ST_MUL_B1: begin
        cmd.op     = llf_pkg::OP_MUL_B1;
        state_next = llf_pkg::ST_MUL_A1;
      end
      llf_pkg::ST_MUL_A1: begin
        cmd.op     = llf_pkg::OP_MUL_A1;
        state_next = llf_pkg::ST_STAGE_END;
      end
      llf_pkg::ST_STAGE_END: begin
        cmd.op = llf_pkg::OP_STAGE_END;
        if (stage == SW'(STAGES - 1)) begin
          state_next = llf_pkg::ST_OUT;
        end else begin
          stage_next = stage + SW'(1);
          state_next = llf_pkg::ST_MUL_B0;
        end
      end
      llf_pkg::ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          cmd.op        = llf_pkg::OP_LOAD_OUT;
          m_tvalid_next = 1'b1;
          state_next    = llf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = llf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/ladder_lowpass_filter_top.sv @@
// Samples are processed one at a time: a new input transaction is accepted only after
// the previous result has been loaded into the output register. All arithmetic uses the
// one shared multiplier: feedback, tanh interpolation, then three products per stage.
// The output register frees the input side while a result waits to be taken.
// Reset (rst, synchronous): coefficients to defaults, stage history cleared at once.
// The tanh ROM is constant and needs no fill after reset.
module ladder_lowpass_filter_top #(
  parameter int STAGES           = 4,
  parameter int TANH_TABLE_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [llf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [llf_pkg::COEF_W-1:0]    cfg_wdata,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [15:0]                   s_tdata,   // [15:0] sample_in
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [15:0]                   m_tdata    // [15:0] sample_out
);

  llf_pkg::dp_cmd_t cmd;

  llf_ctrl #(
    .STAGES(STAGES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  llf_datapath #(
    .STAGES           (STAGES),
    .TANH_TABLE_DEPTH (TANH_TABLE_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .sample_in  ($signed(s_tdata)),
    .cmd        (cmd),
    .sample_out (m_tdata)
  );

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the ladder lowpass filter with a built-in fixed-point predictor.
module tb;
  import llf_pkg::*;

  localparam int N_STAGES  = 4;
  localparam int LUT_DEPTH = 1024;
  localparam longint STAGE_MAX = 64'sd8388607;
  localparam longint STAGE_MIN = -64'sd8388608;
  localparam longint SMP_MAX = 64'sd32767;
  localparam longint SMP_MIN = -64'sd32768;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0] cfg_wdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [15:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [15:0] m_tdata;

  ladder_lowpass_filter_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always #4 clk = ~clk;

  // filter model state
  longint gain_b0 = 0;
  longint gain_b1 = 0;
  longint gain_a1 = 65536;
  longint res_g = 0;
  longint hist_in[N_STAGES];
  longint hist_out[N_STAGES];
  longint tanh_lut[LUT_DEPTH];

  logic [15:0] expected_out[$];
  logic [15:0] want_out;
  int err_count = 0;
  bit tx_jitter = 1'b1;
  bit rx_jitter = 1'b1;
  int hold_left = 0;

  function automatic void build_tanh_lut();
    longint unsigned one, step, term, ratio, e, den, num;
    one = 64'd1 << 30;
    step = (64'd16 * one) / LUT_DEPTH;
    term = one;
    ratio = one;
    e = one;
    for (int i = 1; i <= 20; i++) begin
      term = ((term * step) >> 30) / longint'(i);
      if (i % 2 == 1) ratio -= term;
      else ratio += term;
    end
    for (int k = 0; k < LUT_DEPTH; k++) begin
      den = one + e;
      num = (one - e) * 64'd16384 + den / 2;
      tanh_lut[k] = longint'(num / den);
      e = (e * ratio + one / 2) >> 30;
    end
  endfunction

  function automatic longint rnd_shift(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint sat(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint tanh_fix(longint x);
    longint mag, pos, idx, frac, lo, hi, t;
    mag = x < 0 ? -x : x;
    pos = mag * LUT_DEPTH;
    idx = pos >>> FRAC_W;
    frac = pos & ((64'sd1 <<< FRAC_W) - 1);
    if (idx >= LUT_DEPTH) begin
      t = longint'(TANH_ONE);
    end else begin
      lo = tanh_lut[idx];
      hi = (idx + 1 < LUT_DEPTH) ? tanh_lut[idx + 1] : longint'(TANH_ONE);
      t = lo + rnd_shift((hi - lo) * frac, FRAC_W);
    end
    return x < 0 ? -t : t;
  endfunction

  function automatic logic [15:0] filter_sample(logic signed [15:0] smp_in);
    longint smp, acc, xs, sum, y;
    smp = smp_in;
    acc = 2 * res_g * smp - 4 * res_g * hist_out[N_STAGES-1];
    xs = tanh_fix(smp + rnd_shift(acc, 16));
    for (int s = 0; s < N_STAGES; s++) begin
      sum = gain_b0 * xs + gain_b1 * hist_in[s] + gain_a1 * hist_out[s];
      y = sat(rnd_shift(sum, 16), STAGE_MIN, STAGE_MAX);
      hist_in[s] = xs;
      hist_out[s] = y;
      xs = y;
    end
    return 16'(sat(xs, SMP_MIN, SMP_MAX));
  endfunction

  // receiver: random ready, steady ready, or a counted hold-off
  always @(posedge clk) begin
    if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (rx_jitter) begin
      m_tready <= ($urandom_range(99) >= 38);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_out.size() == 0) begin
        $error("sample_out: expected none, got %0d", $signed(m_tdata));
        err_count++;
      end else begin
        want_out = expected_out.pop_front();
        if (m_tdata !== want_out) begin
          $error("sample_out: expected %0d, got %0d", $signed(want_out), $signed(m_tdata));
          err_count++;
        end
      end
    end
  end

  // valid stays high on return; the next call or drain_outputs decides what follows
  task automatic send_sample(input logic signed [15:0] smp);
    while (tx_jitter && $urandom_range(99) < 38) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= smp;
    do @(posedge clk); while (!s_tready);
    expected_out.push_back(filter_sample(smp));
  endtask

  task automatic drain_outputs();
    s_tvalid <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] w);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= w;
    @(posedge clk);
    case (idx)
      REG_COEF_B0:  gain_b0 = longint'($signed(w));
      REG_COEF_B1:  gain_b1 = longint'($signed(w));
      REG_COEF_A1:  gain_a1 = longint'($signed(w));
      REG_RES_GAIN: res_g = longint'(w);
      default: ;
    endcase
  endtask

  task automatic set_filter(input longint b0, input longint b1, input longint a1,
                            input longint g);
    drain_outputs();
    write_reg(REG_COEF_B0, b0[COEF_W-1:0]);
    write_reg(REG_COEF_B1, b1[COEF_W-1:0]);
    write_reg(REG_COEF_A1, a1[COEF_W-1:0]);
    write_reg(REG_RES_GAIN, g[COEF_W-1:0]);
    cfg_we <= 1'b0;
  endtask

  // all stage outputs to zero so the feedback term starts from nothing
  task automatic zero_history();
    set_filter(0, 0, 0, 0);
    send_sample(16'sd0);
  endtask

  task automatic test_reset_state();
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
    send_sample(16'sd1);
    send_sample(-16'sd1);
  endtask

  // unity stages, no resonance: output is tanh of the input
  task automatic test_tanh_curve();
    set_filter(65536, 0, 0, 0);
    send_sample(16'sd0);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
    send_sample(16'sd16384);
    send_sample(16'h5555);
    send_sample(16'hAAAA);
  endtask

  // last table entry and past the table end, both signs
  task automatic test_tanh_ends();
    zero_history();
    set_filter(65536, 0, 0, 229376);
    send_sample(16'sd16375);
    zero_history();
    set_filter(65536, 0, 0, 229376);
    send_sample(-16'sd16375);
    zero_history();
    set_filter(65536, 0, 0, 229376);
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
  endtask

  task automatic test_saturation();
    set_filter(131071, 131071, 131071, 0);
    repeat (3) send_sample(16'sd32767);
    set_filter(-131072, -131072, -131072, 262143);
    send_sample(-16'sd32768);
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
  endtask

  task automatic random_setting();
    longint gc;
    longint pick[3];
    case ($urandom_range(2))
      0: begin
        gc = $urandom_range(1000, 60000);
        set_filter(gc * 10 / 13, gc * 3 / 13, 65536 - gc, $urandom_range(262143));
      end
      1: begin
        set_filter(longint'($signed(18'($urandom))), longint'($signed(18'($urandom))),
                   longint'($signed(18'($urandom))), $urandom_range(262143));
      end
      default: begin
        pick[0] = -131072;
        pick[1] = 0;
        pick[2] = 131071;
        set_filter(pick[$urandom_range(2)], pick[$urandom_range(2)], pick[$urandom_range(2)],
                   $urandom_range(1) ? 262143 : 0);
      end
    endcase
  endtask

  task automatic random_samples(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 7) send_sample(16'($urandom));
      else send_sample(16'($signed($urandom_range(4095)) - 2048));
    end
  endtask

  task automatic test_random_settings();
    for (int p = 0; p < 14; p++) begin
      random_setting();
      random_samples(110);
    end
  endtask

  task automatic test_back_to_back();
    random_setting();
    tx_jitter = 1'b0;
    rx_jitter = 1'b0;
    random_samples(150);
    drain_outputs();
    tx_jitter = 1'b1;
    rx_jitter = 1'b1;
  endtask

  task automatic test_output_backpressure();
    random_setting();
    hold_left <= HOLD_CYCLES;
    random_samples(20);
  endtask

  initial begin
    for (int s = 0; s < N_STAGES; s++) begin
      hist_in[s] = 0;
      hist_out[s] = 0;
    end
    build_tanh_lut();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_tanh_curve();
    test_tanh_ends();
    test_saturation();
    test_random_settings();
    test_back_to_back();
    test_output_backpressure();
    drain_outputs();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #4_800_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
